>>> design/abnt_pkg.sv
package abnt_pkg;

    // Field widths of the channels
    localparam int CAND_WIDTH = 20;
    localparam int SUM_WIDTH  = 23;

    // Operand width actually examined (low bits of the candidate)
    localparam int NUM_WIDTH  = 20;

    // Exact divisor-sum width: sigma(n)/n stays below 8 in range
    localparam int ACC_WIDTH  = NUM_WIDTH + 3;
    localparam int CMP_WIDTH  = (ACC_WIDTH > SUM_WIDTH) ? ACC_WIDTH : SUM_WIDTH;

    // Trial divisor, its square, and divider step count
    localparam int D_WIDTH    = NUM_WIDTH / 2 + 1;
    localparam int SQ_WIDTH   = NUM_WIDTH + 1;
    localparam int CNT_WIDTH  = $clog2(NUM_WIDTH);

    localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_ACC,
        S_FIN
    } t_state;

    function automatic logic [SUM_WIDTH-1:0] sat_sum(input logic [ACC_WIDTH-1:0] v);
        logic [CMP_WIDTH-1:0] ext;
        ext = CMP_WIDTH'(v);
        if (ext > CMP_WIDTH'(SUM_MAX)) begin
            return SUM_MAX;
        end
        return SUM_WIDTH'(ext);
    endfunction

endpackage

>>> design/abnt_in_if.sv
interface abnt_in_if import abnt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CAND_WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

>>> design/abnt_out_if.sv
interface abnt_out_if import abnt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 is_abundant;
    logic [SUM_WIDTH-1:0] divisor_sum;
    logic [SUM_WIDTH-1:0] abundance;

    modport source (output valid, output is_abundant, output divisor_sum,
                    output abundance, input ready);
    modport sink   (input valid, input is_abundant, input divisor_sum,
                    input abundance, output ready);
endinterface

>>> design/abundant_number_test.sv
// Each trial divisor passes through a check state, NUM_WIDTH radix-2 divide steps and an
// accumulate state; a candidate below 2 goes from the check state straight to finish.
// Throughput: one candidate at a time, set by the single restoring divider
// that every trial shares.
// The result sits in an output register, so a new candidate is taken while it waits.
// Reset (i_rst_n, synchronous, active low) returns the sequencer to idle and drops o_res.valid.
module abundant_number_test import abnt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    abnt_in_if.sink     i_cand,
    abnt_out_if.source  o_res
);

    // Sequencer
    t_state r_state;
    t_state n_state;

    // Datapath registers
    logic [NUM_WIDTH-1:0] r_n;      // candidate under test
    logic [D_WIDTH-1:0]   r_d;      // current trial divisor
    logic [SQ_WIDTH-1:0]  r_sq;     // r_d squared, kept by running sum
    logic [NUM_WIDTH-1:0] r_quo;    // dividend shifting out, quotient shifting in
    logic [D_WIDTH-1:0]   r_rem;    // partial remainder, always below r_d
    logic [CNT_WIDTH-1:0] r_cnt;    // divide steps left after the current one
    logic [ACC_WIDTH-1:0] r_total;  // running proper-divisor sum

    // Output register
    logic                 r_out_valid;
    logic                 r_out_ab;
    logic [SUM_WIDTH-1:0] r_out_sum;
    logic [SUM_WIDTH-1:0] r_out_abn;

    // Strobes from the sequencer
    logic in_take;
    logic div_load;
    logic div_step;
    logic acc_step;
    logic out_load;

    // Shared divider: one compare-subtract per cycle
    logic [D_WIDTH:0]   trial;
    logic [D_WIDTH+1:0] diff;
    logic               ge;

    // Accumulate and result paths
    logic                 trial_done;
    logic                 out_free;
    logic [ACC_WIDTH-1:0] addend;
    logic                 res_ab;
    logic [SUM_WIDTH-1:0] res_abn;

    assign trial = {r_rem, r_quo[NUM_WIDTH-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_d};
    assign ge    = ~diff[D_WIDTH+1];

    // Stop once d*d exceeds n; n below 2 has no proper divisors worth summing
    assign trial_done = (r_n < NUM_WIDTH'(2)) || (r_sq > SQ_WIDTH'(r_n));
    assign out_free   = ~r_out_valid | o_res.ready;

    // d pairs with cofactor n/d; d = 1 pairs with n itself, which is excluded
    always_comb begin
        if (r_rem != '0) begin
            addend = '0;
        end else if (r_d == D_WIDTH'(1)) begin
            addend = ACC_WIDTH'(1);
        end else if (r_quo == NUM_WIDTH'(r_d)) begin
            addend = ACC_WIDTH'(r_d);
        end else begin
            addend = ACC_WIDTH'(r_d) + ACC_WIDTH'(r_quo);
        end
    end

    assign res_ab  = r_total > ACC_WIDTH'(r_n);
    assign res_abn = res_ab ? sat_sum(r_total - ACC_WIDTH'(r_n)) : '0;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cand.valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = trial_done ? S_FIN : S_DIV;
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = S_CHECK;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        in_take  = 1'b0;
        div_load = 1'b0;
        div_step = 1'b0;
        acc_step = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE:  in_take  = i_cand.valid;
            S_CHECK: div_load = ~trial_done;
            S_DIV:   div_step = 1'b1;
            S_ACC:   acc_step = 1'b1;
            S_FIN:   out_load = out_free;
            default: ;
        endcase
    end

    assign i_cand.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_n     <= NUM_WIDTH'({{NUM_WIDTH{1'b0}}, i_cand.candidate});
            r_d     <= D_WIDTH'(1);
            r_sq    <= SQ_WIDTH'(1);
            r_total <= '0;
        end
        if (div_load) begin
            r_quo <= r_n;
            r_rem <= '0;
            r_cnt <= CNT_WIDTH'(NUM_WIDTH - 1);
        end
        if (div_step) begin
            r_quo <= {r_quo[NUM_WIDTH-2:0], ge};
            r_rem <= ge ? diff[D_WIDTH-1:0] : trial[D_WIDTH-1:0];
            r_cnt <= r_cnt - CNT_WIDTH'(1);
        end
        if (acc_step) begin
            r_total <= r_total + addend;
            r_d     <= r_d + D_WIDTH'(1);
            // (d+1)^2 = d^2 + 2d + 1
            r_sq    <= r_sq + SQ_WIDTH'({r_d, 1'b1});
        end
    end

    // Output register: holds one finished beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ab  <= res_ab;
            r_out_sum <= sat_sum(r_total);
            r_out_abn <= res_abn;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.is_abundant = r_out_ab;
    assign o_res.divisor_sum = r_out_sum;
    assign o_res.abundance   = r_out_abn;

`ifndef SYNTHESIS
    a_rem_below_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_d))
        else $error("partial remainder not below divisor");

    a_sq_tracks_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |->
        ((2*D_WIDTH)'(r_d) * (2*D_WIDTH)'(r_d) == (2*D_WIDTH)'(r_sq)))
        else $error("running square out of step with divisor");

    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cand.valid && i_cand.ready) |=> (r_state == S_CHECK))
        else $error("accepted beat did not start a test");

    a_abn_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ab) |-> (r_out_abn != '0))
        else $error("abundant result with zero abundance");

    a_abn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ab) |-> (r_out_abn == '0))
        else $error("non-abundant result with nonzero abundance");
`endif

endmodule

>>> sim/tb_abundant_number_test.sv
`timescale 1ns / 1ps

module tb_abundant_number_test;
    import abnt_pkg::*;

    // No beat on either channel for this many cycles means the block is hung.
    // The limit leaves margin over the slowest candidate.
    localparam int HANG_LIMIT     = 200000;
    // Quiet cycles after the last result, to catch a stray extra beat.
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 100;
    localparam int IDLE_PCT       = 31;
    // Window of beats during which neither side idles.
    localparam int STEADY_FIRST   = 50;
    localparam int STEADY_LAST    = 90;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic                 is_abundant;
        logic [SUM_WIDTH-1:0] divisor_sum;
        logic [SUM_WIDTH-1:0] abundance;
    } t_abundance_verdict;

    logic i_clk;
    logic i_rst_n;

    abnt_in_if  cand ();
    abnt_out_if res ();

    abundant_number_test uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cand  (cand),
        .o_res   (res)
    );

    logic [CAND_WIDTH-1:0] pending_candidates[$];
    t_abundance_verdict    expected_verdicts[$];

    int  total_candidates    = 0;
    int  accepted_candidates = 0;
    int  returned_verdicts   = 0;
    int  error_count         = 0;
    int  hang_cycles         = 0;
    // Set at each rising edge: the input beat offered there was taken.
    bit  in_beat             = 1'b0;

    // Sum of proper divisors by pairing each divisor below the square root
    // with its cofactor, then the abundant verdict on the exact sum.
    function automatic t_abundance_verdict judge_candidate(logic [CAND_WIDTH-1:0] raw);
        longint unsigned    n;
        longint unsigned    total;
        longint unsigned    d;
        longint unsigned    co;
        t_abundance_verdict v;
        n     = longint'(raw) & ((64'd1 << NUM_WIDTH) - 1);
        total = 0;
        if (n >= 2) begin
            for (d = 1; d * d <= n; d++) begin
                if (n % d == 0) begin
                    co    = n / d;
                    total += d;
                    if (co != d) begin
                        total += co;
                    end
                end
            end
            total -= n;
        end
        v.is_abundant = (total > n);
        v.divisor_sum = (total > SUM_MAX) ? SUM_MAX : total[SUM_WIDTH-1:0];
        if (!v.is_abundant) begin
            v.abundance = '0;
        end else if (total - n > SUM_MAX) begin
            v.abundance = SUM_MAX;
        end else begin
            v.abundance = SUM_WIDTH'(total - n);
        end
        return v;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Driver: everything moves on the falling edge. A held beat stays put
    // until the rising edge that takes it; only then is the next one offered.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cand.valid <= 1'b0;
            res.ready  <= 1'b0;
        end else begin
            if (!cand.valid || in_beat) begin
                if (pending_candidates.size() != 0 &&
                    ((accepted_candidates >= STEADY_FIRST &&
                      accepted_candidates < STEADY_LAST) ||
                     $urandom_range(99) >= IDLE_PCT)) begin
                    cand.valid     <= 1'b1;
                    cand.candidate <= pending_candidates.pop_front();
                end else begin
                    // junk on the bus while idle
                    cand.valid     <= 1'b0;
                    cand.candidate <= CAND_WIDTH'($urandom);
                end
            end
            res.ready <= (returned_verdicts >= STEADY_FIRST &&
                          returned_verdicts < STEADY_LAST) ||
                         ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: samples both channels at the rising edge. The result beat is
    // checked before the new candidate is queued, so a verdict never pairs
    // with a candidate taken in the same cycle.
    always @(posedge i_clk) begin
        t_abundance_verdict want;
        if (i_rst_n) begin
            in_beat = cand.valid && cand.ready;

            if (res.valid && res.ready) begin
                returned_verdicts++;
                if (expected_verdicts.size() == 0) begin
                    flag_error($sformatf("unexpected verdict ab=%0b sum=%0d abund=%0d",
                                         res.is_abundant, res.divisor_sum, res.abundance));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (res.is_abundant !== want.is_abundant ||
                        res.divisor_sum !== want.divisor_sum ||
                        res.abundance   !== want.abundance) begin
                        flag_error($sformatf(
                            "verdict %0d: exp ab=%0b sum=%0d abund=%0d, got ab=%0b sum=%0d abund=%0d",
                            returned_verdicts, want.is_abundant, want.divisor_sum,
                            want.abundance, res.is_abundant, res.divisor_sum,
                            res.abundance));
                    end
                end
            end

            if (in_beat) begin
                expected_verdicts.push_back(judge_candidate(cand.candidate));
                accepted_candidates++;
            end

            // hang watchdog
            if (in_beat || (res.valid && res.ready)) begin
                hang_cycles = 0;
            end else begin
                hang_cycles++;
                if (hang_cycles >= HANG_LIMIT) begin
                    $display("abundant_number_test verification failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        int                    r;
        logic [CAND_WIDTH-1:0] c;

        i_rst_n        = 1'b0;
        cand.valid     = 1'b0;
        cand.candidate = '0;
        res.ready      = 1'b0;

        // Directed: zero and one (no proper divisors), smallest prime,
        // perfect numbers (sum equals the candidate, so not abundant),
        // the first even and the first odd abundant numbers, powers of two,
        // a large square (divisor equals its cofactor), a large prime,
        // all ones, and highly composite values with the biggest sums.
        pending_candidates = '{
            20'd0, 20'd1, 20'd2, 20'd3, 20'd6, 20'd12, 20'd18, 20'd28,
            20'd496, 20'd945, 20'd1024, 20'd5040, 20'd8128, 20'd524288,
            20'd720720, 20'd831600, 20'd1046529, 20'd1048573, 20'd1048575
        };

        // Random: mostly small candidates to keep trial division short,
        // a share of multiples of 12 to hit abundant numbers often, and a
        // few full-width ones to exercise the top bits.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            r = $urandom_range(99);
            if (r < 15) begin
                c = CAND_WIDTH'(12 * $urandom_range(341));
            end else if (r < 60) begin
                c = CAND_WIDTH'($urandom_range(4095));
            end else if (r < 90) begin
                c = CAND_WIDTH'($urandom_range(65535));
            end else begin
                c = CAND_WIDTH'($urandom);
            end
            pending_candidates.push_back(c);
        end
        total_candidates = pending_candidates.size();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (accepted_candidates < total_candidates) @(posedge i_clk);
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_verdicts.size() == 0) begin
            $display("abundant_number_test verification clean");
        end else begin
            $display("abundant_number_test verification failed");
        end
        $finish;
    end

endmodule
